/* design/dfrg_pkg.sv */
// Shared constants, codes and handshake structs of the frame rate governor.
`timescale 1ns / 1ps
`default_nettype none

package dfrg_pkg;

  localparam int VIEW_SLOTS_DEF = 16;

  localparam int CMD_W   = 3;
  localparam int RATE_W  = 10;
  localparam int ID_W    = 16;
  localparam int STRAT_W = 2;
  localparam int HOLD_W  = 12;
  localparam int CFGR_W  = 9;
  localparam int VSYNC_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [HOLD_W-1:0] HOLD_DEF       = HOLD_W'(3000);
  localparam logic [CFGR_W-1:0] RATE_TOUCH_DEF = CFGR_W'(120);
  localparam logic [CFGR_W-1:0] RATE_IDLE_DEF  = CFGR_W'(60);
  localparam logic [VSYNC_W-1:0] VSYNC_MAX     = '1;

  localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_VIDEO  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_VSYNC  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VIS    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RATE  = 2'd3;

  localparam logic [STRAT_W-1:0] STRAT_NONE   = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_SCROLL = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_ALL    = 2'd2;

  typedef struct packed {
    logic latch;
    logic scan_step;
    logic apply;
  } dfrg_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_last;
    logic out_free;
  } dfrg_sts_t;

endpackage

`default_nettype wire

/* design/display_frame_rate_governor_unit.sv */
// Top level of the display frame rate governor.
// Each event is latched on accept and its result registered in the apply step; a visibility event
// under an enabled policy first scans the view table one slot per cycle through the id RAM read port.
// A new event is not accepted until the apply step of the last one is done; a stalled result
// holds the apply step and so the next accept.
// Reset: synchronous active-low rst_n clears state, valid bits and counters, loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module display_frame_rate_governor_unit
  import dfrg_pkg::*;
#(
  parameter int VIEW_SLOTS = VIEW_SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         in_cmd,
  input  wire logic signed [RATE_W-1:0] in_rate,
  input  wire logic                     in_flag,
  input  wire logic [ID_W-1:0]          in_view_id,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_rate_valid,
  output logic signed [RATE_W-1:0]      out_preferred_rate,
  output logic                          out_link_enable,
  output logic                          out_link_changed,
  output logic                          out_table_full
);

  dfrg_cmd_t cmd;
  dfrg_sts_t sts;

  dfrg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  dfrg_dp #(
    .VIEW_SLOTS(VIEW_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_rate           (in_rate),
    .in_flag           (in_flag),
    .in_view_id        (in_view_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rate_valid    (out_rate_valid),
    .out_preferred_rate(out_preferred_rate),
    .out_link_enable   (out_link_enable),
    .out_link_changed  (out_link_changed),
    .out_table_full    (out_table_full),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

/* design/dfrg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dfrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/dfrg_ctrl.sv */
// Controller state machine: accept, table scan, drain, result apply.
`timescale 1ns / 1ps
`default_nettype none

module dfrg_ctrl
  import dfrg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dfrg_sts_t sts,
  output dfrg_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  state_t state_r;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd.latch     = (state_r == ST_IDLE) && in_valid;
    cmd.scan_step = (state_r == ST_SCAN);
    cmd.apply     = (state_r == ST_APPLY) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= sts.needs_scan ? ST_SCAN : ST_APPLY;
          end
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_apply_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> sts.out_free)
    else $error("apply without room in output register");
`endif

endmodule

`default_nettype wire

/* design/dfrg_dp.sv */
// Datapath: configuration, governor state, view table scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module dfrg_dp
  import dfrg_pkg::*;
#(
  parameter int VIEW_SLOTS = VIEW_SLOTS_DEF,
  localparam int IDX_W = (VIEW_SLOTS > 1) ? $clog2(VIEW_SLOTS) : 1,
  localparam int CNT_W = $clog2(VIEW_SLOTS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic signed [RATE_W-1:0] in_rate,
  input  wire logic                    in_flag,
  input  wire logic [ID_W-1:0]         in_view_id,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_rate_valid,
  output logic signed [RATE_W-1:0]     out_preferred_rate,
  output logic                         out_link_enable,
  output logic                         out_link_changed,
  output logic                         out_table_full,
  input  wire dfrg_cmd_t               cmd,
  output dfrg_sts_t                    sts
);

  logic [STRAT_W-1:0] strategy_r;
  logic [HOLD_W-1:0]  hold_ms_r;
  logic [CFGR_W-1:0]  touch_rate_r;
  logic [CFGR_W-1:0]  idle_rate_r;

  logic signed [RATE_W-1:0] scroll_r, scroll_nxt;
  logic signed [RATE_W-1:0] video_r, video_nxt;
  logic [VSYNC_W-1:0]       vsync_r, vsync_nxt;
  logic                     touch_r, touch_nxt;
  logic [HOLD_W-1:0]        hold_r, hold_nxt;
  logic                     link_r, link_nxt;
  logic [CNT_W-1:0]         vis_cnt_r, vis_cnt_nxt;
  logic [VIEW_SLOTS-1:0]    vvalid_r;

  logic [CMD_W-1:0]         cmd_r;
  logic signed [RATE_W-1:0] rate_r;
  logic                     flag_r;
  logic [ID_W-1:0]          vid_r;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             rd_pend_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [ID_W-1:0]  ram_rdata;

  logic                     out_valid_r;
  logic                     out_rate_valid_r;
  logic signed [RATE_W-1:0] out_pref_r;
  logic                     out_link_r;
  logic                     out_changed_r;
  logic                     out_full_r;

  logic fling_ok, all_ok;
  logic do_update, full, ins, rem;
  logic signed [RATE_W-1:0] base_rate, cur_rate;

  assign fling_ok = (strategy_r == STRAT_SCROLL) || (strategy_r == STRAT_ALL);
  assign all_ok   = (strategy_r == STRAT_ALL);

  assign sts.needs_scan = (in_cmd == CMD_VIS) && fling_ok;
  assign sts.scan_last  = (idx_r == IDX_W'(VIEW_SLOTS - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  dfrg_ram #(
    .WIDTH(ID_W),
    .DEPTH(VIEW_SLOTS)
  ) u_ids (
    .clk  (clk),
    .we   (ins),
    .waddr(free_idx_r),
    .wdata(vid_r),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    scroll_nxt  = scroll_r;
    video_nxt   = video_r;
    vsync_nxt   = vsync_r;
    touch_nxt   = touch_r;
    hold_nxt    = hold_r;
    do_update   = 1'b0;
    full        = 1'b0;
    ins         = 1'b0;
    rem         = 1'b0;
    vis_cnt_nxt = vis_cnt_r;
    unique case (cmd_r)
      CMD_SCROLL: begin
        if (fling_ok && (scroll_r != rate_r)) begin
          scroll_nxt = rate_r;
          do_update  = 1'b1;
        end
      end
      CMD_VIDEO: begin
        if (all_ok && (video_r != rate_r)) begin
          video_nxt = rate_r;
          do_update = 1'b1;
        end
      end
      CMD_VSYNC: begin
        if (flag_r) begin
          if (vsync_r != VSYNC_MAX) begin
            vsync_nxt = vsync_r + VSYNC_W'(1);
          end
        end else if (vsync_r != '0) begin
          vsync_nxt = vsync_r - VSYNC_W'(1);
        end
        do_update = 1'b1;
      end
      CMD_TOUCH: begin
        if (all_ok && (touch_r != flag_r)) begin
          touch_nxt = flag_r;
          if (flag_r) begin
            do_update = 1'b1;
          end else if ((scroll_r == '0) && (vsync_r != '0)) begin
            hold_nxt = hold_ms_r;
          end
        end
      end
      CMD_VIS: begin
        if (fling_ok) begin
          if (flag_r) begin
            if (!found_r) begin
              if (free_r) begin
                ins = 1'b1;
              end else begin
                full = 1'b1;
              end
            end
          end else if (found_r) begin
            rem = 1'b1;
          end
          do_update = 1'b1;
        end
      end
      CMD_TICK: begin
        if (hold_r != '0) begin
          hold_nxt  = hold_r - HOLD_W'(1);
          do_update = (hold_r == HOLD_W'(1));
        end
      end
      default: begin
      end
    endcase
    if (ins) begin
      vis_cnt_nxt = vis_cnt_r + CNT_W'(1);
    end else if (rem) begin
      vis_cnt_nxt = vis_cnt_r - CNT_W'(1);
    end
    link_nxt = (vis_cnt_nxt != '0) && (vsync_nxt != '0);

    if (touch_nxt || (hold_nxt != '0)) begin
      base_rate = $signed({1'b0, touch_rate_r});
    end else if (video_nxt > 0) begin
      base_rate = video_nxt;
    end else begin
      base_rate = $signed({1'b0, idle_rate_r});
    end
    cur_rate = (scroll_nxt > 0) ? scroll_nxt : base_rate;
    if (video_nxt > cur_rate) begin
      cur_rate = video_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r   <= STRAT_NONE;
      hold_ms_r    <= HOLD_DEF;
      touch_rate_r <= RATE_TOUCH_DEF;
      idle_rate_r  <= RATE_IDLE_DEF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STRATEGY:   strategy_r   <= cfg_wdata[STRAT_W-1:0];
        CFG_HOLD_MS:    hold_ms_r    <= cfg_wdata[HOLD_W-1:0];
        CFG_TOUCH_RATE: touch_rate_r <= cfg_wdata[CFGR_W-1:0];
        CFG_IDLE_RATE:  idle_rate_r  <= cfg_wdata[CFGR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r  <= '0;
      video_r   <= '0;
      vsync_r   <= '0;
      touch_r   <= 1'b0;
      hold_r    <= '0;
      link_r    <= 1'b0;
      vis_cnt_r <= '0;
      vvalid_r  <= '0;
    end else if (cmd.apply) begin
      scroll_r  <= scroll_nxt;
      video_r   <= video_nxt;
      vsync_r   <= vsync_nxt;
      touch_r   <= touch_nxt;
      hold_r    <= hold_nxt;
      link_r    <= link_nxt;
      vis_cnt_r <= vis_cnt_nxt;
      if (ins) begin
        vvalid_r[free_idx_r] <= 1'b1;
      end
      if (rem) begin
        vvalid_r[found_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_cmd;
      rate_r <= in_rate;
      flag_r <= in_flag;
      vid_r  <= in_view_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_step;
      if (cmd.latch) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          idx_r <= idx_r + IDX_W'(1);
          if (!vvalid_r[idx_r] && !free_r) begin
            free_r <= 1'b1;
          end
        end
        if (rd_pend_r && vvalid_r[cmp_idx_r] && (ram_rdata == vid_r) && !found_r) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (cmd.scan_step && !vvalid_r[idx_r] && !free_r) begin
      free_idx_r <= idx_r;
    end
    if (rd_pend_r && vvalid_r[cmp_idx_r] && (ram_rdata == vid_r) && !found_r) begin
      found_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_rate_valid_r <= do_update && link_nxt;
      out_pref_r       <= (do_update && link_nxt) ? cur_rate : '0;
      out_link_r       <= link_nxt;
      out_changed_r    <= (link_nxt != link_r);
      out_full_r       <= full;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rate_valid     = out_rate_valid_r;
  assign out_preferred_rate = out_pref_r;
  assign out_link_enable    = out_link_r;
  assign out_link_changed   = out_changed_r;
  assign out_table_full     = out_full_r;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vvalid_r) == int'(vis_cnt_r))
    else $error("visible count out of step with valid bits");
  a_link_state: assert property (@(posedge clk) disable iff (!rst_n)
    link_r == ((vis_cnt_r != '0) && (vsync_r != '0)))
    else $error("link state out of step with table and vsync count");
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (vis_cnt_r == CNT_W'(VIEW_SLOTS)))
    else $error("insert dropped while table had room");
`endif

endmodule

`default_nettype wire
